### rtl/core/ilo_pkg.sv
// Shared constants, microcode types and status/control structs for the overlap correlator.
`timescale 1ns / 1ps

package ilo_pkg;

    localparam int HIST_DEPTH = 1024;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LEN_W      = HIST_AW + 1;
    localparam int READ_DEPTH = 256;
    localparam int PROB_BITS  = 16;
    localparam int PROD_BITS  = 2 * PROB_BITS;
    localparam int SUM_BITS   = 42;

    localparam int MIN_W    = 10;
    localparam int MAXI_W   = 11;
    localparam int MAXR_W   = 9;
    localparam int STRAND_W = 11;
    localparam int READ_W   = 8;
    localparam int OFS_W    = STRAND_W + 1;
    localparam int TIDX_W   = LEN_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INSERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INSERT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_READ   = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_QINIT,
        S_QCHK,
        S_ISSUE,
        S_DRAIN1,
        S_DRAIN2,
        S_OUT,
        S_LOAD
    } step_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_CLR_MORE,
        C_NO_IN,
        C_IS_LOAD,
        C_SKIP,
        C_LOOP_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  in_rdy;
        logic  clr_wr;
        logic  ld_wr;
        logic  q_init;
        logic  issue;
        logic  out_ld;
        cond_t wait_cond;
        cond_t jump_cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic clr_more;
        logic in_valid;
        logic is_load;
        logic skip;
        logic loop_more;
        logic out_busy;
    } status_t;

endpackage

### rtl/core/ilo_ram.sv
// Generic memory with one write port and two registered read ports.
`timescale 1ns / 1ps

module ilo_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] ra_addr,
    input  logic [AW-1:0] rb_addr,
    output logic [DW-1:0] ra_data,
    output logic [DW-1:0] rb_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

### rtl/core/ilo_ucode.sv
// Microcode sequencer: step counter, control ROM and wait/jump resolution.
`timescale 1ns / 1ps

module ilo_ucode (
    input  logic              clk,
    input  logic              rst_n,
    input  ilo_pkg::status_t  stat,
    output ilo_pkg::ctrl_t    ctrl
);

    import ilo_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  wait_hit;
    logic  jump_hit;

    function automatic logic cond_eval(input cond_t c, input status_t st);
        logic r;
        case (c)
            C_NEVER:     r = 1'b0;
            C_ALWAYS:    r = 1'b1;
            C_CLR_MORE:  r = st.clr_more;
            C_NO_IN:     r = !st.in_valid;
            C_IS_LOAD:   r = st.is_load;
            C_SKIP:      r = st.skip;
            C_LOOP_MORE: r = st.loop_more;
            C_OUT_BUSY:  r = st.out_busy;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    // Control ROM: one word per step.
    always_comb
    begin
        ctrl = '{in_rdy: 1'b0, clr_wr: 1'b0, ld_wr: 1'b0, q_init: 1'b0, issue: 1'b0,
                 out_ld: 1'b0, wait_cond: C_NEVER, jump_cond: C_NEVER, target: S_IDLE};
        case (step_reg)
            S_CLEAR:
            begin
                ctrl.clr_wr    = 1'b1;
                ctrl.wait_cond = C_CLR_MORE;
            end
            S_IDLE:
            begin
                ctrl.in_rdy    = 1'b1;
                ctrl.wait_cond = C_NO_IN;
            end
            S_DISPATCH:
            begin
                ctrl.jump_cond = C_IS_LOAD;
                ctrl.target    = S_LOAD;
            end
            S_QINIT:
            begin
                ctrl.q_init = 1'b1;
            end
            S_QCHK:
            begin
                ctrl.jump_cond = C_SKIP;
                ctrl.target    = S_OUT;
            end
            S_ISSUE:
            begin
                ctrl.issue     = 1'b1;
                ctrl.wait_cond = C_LOOP_MORE;
            end
            S_DRAIN1:
            begin
                ctrl.jump_cond = C_NEVER;
            end
            S_DRAIN2:
            begin
                ctrl.jump_cond = C_ALWAYS;
                ctrl.target    = S_OUT;
            end
            S_OUT:
            begin
                ctrl.out_ld    = 1'b1;
                ctrl.wait_cond = C_OUT_BUSY;
                ctrl.jump_cond = C_ALWAYS;
                ctrl.target    = S_IDLE;
            end
            S_LOAD:
            begin
                ctrl.ld_wr     = 1'b1;
                ctrl.jump_cond = C_ALWAYS;
                ctrl.target    = S_OUT;
            end
            default:
            begin
                ctrl.jump_cond = C_ALWAYS;
                ctrl.target    = S_IDLE;
            end
        endcase
    end

    // Next step: hold on a wait, else take a jump, else fall through.
    always_comb
    begin
        wait_hit = cond_eval(ctrl.wait_cond, stat);
        jump_hit = cond_eval(ctrl.jump_cond, stat);
        if (wait_hit)
        begin
            step_next = step_reg;
        end
        else if (jump_hit)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### rtl/core/insert_length_overlap_correlator_core.sv
// Top level of the insert-length overlap correlator: datapath, histogram store and sequencer.
`timescale 1ns / 1ps

// The block keeps a 1024-entry histogram of unsigned Q0.16 insert-length
// probabilities and answers overlap queries against it.
// Input channel (in_valid/in_ready): each word is either a load (kind 0),
// which writes probability at length_index, or a query (kind 1), which asks
// for the sum of h[L]*h[L-strand_offset+read_offset] over the configured
// insert range. Every input word produces exactly one output word on the
// output channel (out_valid/out_ready): overlap_sum and bad_query.
// Configuration channel (cfg_valid/cfg_ready) writes min_insert (index 0),
// max_insert (index 1) and max_read (index 2); it is always ready.
// A load goes through the dispatch and load steps to the output step; a
// query runs init, check, the issue loop over the N insert lengths in range
// and the drain steps, while a bad query or empty range jumps from check to
// output. The sequencer then returns to idle for the next word. The loop
// issues one pair of histogram reads per cycle through the dual read port of
// the store, so N reaches 1024 at full range. After reset all 1024 entries
// are swept to zero, one entry a cycle; no input word is taken meanwhile.
// A finished result sits in the output register; the block accepts the
// next input word meanwhile and only holds in its output step when the
// register is still occupied and the receiver is stalling.

module insert_length_overlap_correlator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [ilo_pkg::HIST_AW-1:0]       length_index,
    input  logic [ilo_pkg::PROB_BITS-1:0]     probability,
    input  logic signed [ilo_pkg::STRAND_W-1:0] strand_offset,
    input  logic [ilo_pkg::READ_W-1:0]        read_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ilo_pkg::SUM_BITS-1:0]      overlap_sum,
    output logic                              bad_query,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ilo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ilo_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import ilo_pkg::*;

    ctrl_t   ctrl;
    status_t stat;

    // Configuration registers.
    logic [MIN_W-1:0]  min_insert_reg;
    logic [MAXI_W-1:0] max_insert_reg;
    logic [MAXR_W-1:0] max_read_reg;

    // Captured input word.
    logic                      kind_reg;
    logic [HIST_AW-1:0]        lidx_reg;
    logic [PROB_BITS-1:0]      prob_reg;
    logic signed [STRAND_W-1:0] s_reg;
    logic [READ_W-1:0]         r_reg;

    // Query loop state.
    logic [HIST_AW-1:0]       clr_cnt_reg;
    logic [LEN_W-1:0]         len_reg;
    logic signed [OFS_W-1:0]  d_reg;
    logic                     skip_reg;
    logic                     bad_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [SUM_BITS-1:0]      acc_reg;
    logic [SUM_BITS:0]        acc_wide;

    // Output register.
    logic                     out_valid_reg;
    logic [SUM_BITS-1:0]      out_sum_reg;
    logic                     out_bad_reg;

    logic                     in_take;
    logic                     out_busy;
    logic [LEN_W-1:0]         emax;
    logic [MAXR_W-1:0]        erd;
    logic signed [TIDX_W-1:0] s_ext;
    logic signed [TIDX_W-1:0] emax_s;
    logic                     bad_now;
    logic signed [OFS_W-1:0]  d_now;
    logic signed [TIDX_W-1:0] t_idx;
    logic                     term_ok;

    logic                     mem_we;
    logic [HIST_AW-1:0]       mem_waddr;
    logic [PROB_BITS-1:0]     mem_wdata;
    logic [PROB_BITS-1:0]     ha_data;
    logic [PROB_BITS-1:0]     hb_data;

    assign in_ready  = ctrl.in_rdy;
    assign in_take   = in_valid && ctrl.in_rdy;
    assign cfg_ready = 1'b1;
    assign out_valid   = out_valid_reg;
    assign overlap_sum = out_sum_reg;
    assign bad_query   = out_bad_reg;
    assign out_busy    = out_valid_reg && !out_ready;

    // Bounds clipped to the store and read depth.
    assign emax = (max_insert_reg > LEN_W'(HIST_DEPTH)) ? LEN_W'(HIST_DEPTH) : max_insert_reg;
    assign erd  = (max_read_reg > MAXR_W'(READ_DEPTH)) ? MAXR_W'(READ_DEPTH) : max_read_reg;

    // Range check of the captured query offsets.
    assign s_ext   = TIDX_W'(s_reg);
    assign emax_s  = $signed({2'b00, emax});
    assign bad_now = (s_ext < -emax_s) || (s_ext >= emax_s) ||
                     ({1'b0, r_reg} >= erd);
    assign d_now   = $signed({{(OFS_W-READ_W){1'b0}}, r_reg}) - OFS_W'(s_reg);

    // Shifted index of the current term.
    assign t_idx   = $signed({2'b00, len_reg}) + TIDX_W'(d_reg);
    assign term_ok = (t_idx > 0) && (t_idx < emax_s);

    assign stat.clr_more  = (clr_cnt_reg != HIST_AW'(HIST_DEPTH - 1));
    assign stat.in_valid  = in_valid;
    assign stat.is_load   = (kind_reg == KIND_LOAD);
    assign stat.skip      = skip_reg;
    assign stat.loop_more = (len_reg != (emax - LEN_W'(1)));
    assign stat.out_busy  = out_busy;

    ilo_ucode u_ucode (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Write port is shared by the reset sweep and loads.
    always_comb
    begin
        mem_we    = ctrl.clr_wr || ctrl.ld_wr;
        mem_waddr = ctrl.clr_wr ? clr_cnt_reg : lidx_reg;
        mem_wdata = ctrl.clr_wr ? '0 : prob_reg;
    end

    ilo_ram #(
        .DEPTH (HIST_DEPTH),
        .DW    (PROB_BITS)
    ) u_hist (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .ra_addr (len_reg[HIST_AW-1:0]),
        .rb_addr (t_idx[HIST_AW-1:0]),
        .ra_data (ha_data),
        .rb_data (hb_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_insert_reg <= '0;
            max_insert_reg <= MAXI_W'(HIST_DEPTH);
            max_read_reg   <= MAXR_W'(READ_DEPTH);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_INSERT: min_insert_reg <= cfg_data[MIN_W-1:0];
                CFG_MAX_INSERT: max_insert_reg <= cfg_data[MAXI_W-1:0];
                CFG_MAX_READ:   max_read_reg   <= cfg_data[MAXR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input capture, query offset latch and product register.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lidx_reg <= length_index;
            prob_reg <= probability;
            s_reg    <= strand_offset;
            r_reg    <= read_offset;
        end
        if (ctrl.q_init)
        begin
            d_reg <= d_now;
        end
        prod_reg <= PROD_BITS'(ha_data) * PROD_BITS'(hb_data);
    end

    assign acc_wide = {1'b0, acc_reg} + (SUM_BITS + 1)'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_LOAD;
            clr_cnt_reg <= '0;
            len_reg     <= '0;
            skip_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (ctrl.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + HIST_AW'(1);
            end
            v1_reg <= ctrl.issue && term_ok;
            v2_reg <= v1_reg;
            if (in_take)
            begin
                kind_reg <= kind;
                acc_reg  <= '0;
                bad_reg  <= 1'b0;
                skip_reg <= 1'b0;
            end
            else if (v2_reg)
            begin
                // Saturate at the largest 42-bit value.
                acc_reg <= acc_wide[SUM_BITS] ? '1 : acc_wide[SUM_BITS-1:0];
            end
            if (ctrl.q_init)
            begin
                bad_reg  <= bad_now;
                skip_reg <= bad_now || ({1'b0, min_insert_reg} >= emax);
                len_reg  <= LEN_W'(min_insert_reg);
            end
            else if (ctrl.issue)
            begin
                len_reg <= len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_ld && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_ld && !out_busy)
        begin
            out_sum_reg <= acc_reg;
            out_bad_reg <= bad_reg;
        end
    end

endmodule
